/* hdl/ihex_pkg.sv */
// Shared types, codes, character constants and microcode table of the Intel HEX record encoder.
`default_nettype none
package ihex_pkg;

	// Input command codes
	localparam logic [1:0] CMD_DATA     = 2'd0;
	localparam logic [1:0] CMD_END_SEG  = 2'd1;
	localparam logic [1:0] CMD_END_FILE = 2'd2;

	// Configuration register indexes
	localparam logic [0:0] REG_SEGMENT_BASE   = 1'b0;
	localparam logic [0:0] REG_SEGMENT_LENGTH = 1'b1;

	// ASCII characters used as literals
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef logic [5:0] pc_t;

	// Character source of a step
	typedef enum logic [2:0] {
		CS_LIT,
		CS_EXCESS,
		CS_ADDR,
		CS_ACS,
		CS_RLEN,
		CS_OFF,
		CS_DATA,
		CS_RSUM
	} csel_t;

	// Jump condition of a step
	typedef enum logic [1:0] {
		C_NEVER,
		C_ALWAYS,
		C_TERM
	} cond_t;

	// Datapath action of a step
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_SET_ADDR,
		ACT_OPEN_REC,
		ACT_TAKE_BYTE
	} act_t;

	typedef struct packed {
		logic        emit;
		csel_t       csel;
		logic [1:0]  nib;
		logic [7:0]  lit;
		cond_t       cond;
		pc_t         target;
		logic        fin;
		act_t        act;
	} ctl_t;

	// Entry points of the microprogram
	localparam pc_t PC_SEG = 6'd0;
	localparam pc_t PC_IGN = 6'd1;
	localparam pc_t PC_EOF = 6'd2;
	localparam pc_t PC_EXC = 6'd14;
	localparam pc_t PC_ADR = 6'd15;
	localparam pc_t PC_HDR = 6'd31;
	localparam pc_t PC_TRM = 6'd40;
	localparam pc_t PC_BYT = 6'd43;
	localparam int  NSTEPS = 45;

	function automatic ctl_t cw(input logic emit, input csel_t csel, input logic [1:0] nib,
			input logic [7:0] lit, input cond_t cond, input pc_t target, input logic fin,
			input act_t act);
		ctl_t c;
		c.emit   = emit;
		c.csel   = csel;
		c.nib    = nib;
		c.lit    = lit;
		c.cond   = cond;
		c.target = target;
		c.fin    = fin;
		c.act    = act;
		return c;
	endfunction

	function automatic ctl_t lit_step(input logic [7:0] ch, input act_t act);
		return cw(1'b1, CS_LIT, 2'd0, ch, C_NEVER, PC_SEG, 1'b0, act);
	endfunction

	function automatic ctl_t hex_step(input csel_t csel, input logic [1:0] nib);
		return cw(1'b1, csel, nib, CH_NUL, C_NEVER, PC_SEG, 1'b0, ACT_NONE);
	endfunction

	localparam ctl_t CW_HALT = cw(1'b0, CS_LIT, 2'd0, CH_NUL, C_NEVER, PC_SEG, 1'b1, ACT_NONE);

	localparam ctl_t UCODE [NSTEPS] = '{
		// end of segment
		cw(1'b0, CS_LIT, 2'd0, CH_NUL, C_NEVER, PC_SEG, 1'b1, ACT_CLEAR),
		// unused command
		CW_HALT,
		// end of file record
		lit_step(CH_COLON, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ONE, ACT_NONE),
		lit_step(CH_F, ACT_NONE),
		lit_step(CH_F, ACT_NONE),
		cw(1'b1, CS_LIT, 2'd0, CH_NL, C_NEVER, PC_SEG, 1'b1, ACT_CLEAR),
		// byte beyond length
		cw(1'b1, CS_EXCESS, 2'd0, CH_NUL, C_NEVER, PC_SEG, 1'b1, ACT_NONE),
		// extended segment address record, falls into the data header
		lit_step(CH_COLON, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_TWO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_ZERO, ACT_NONE),
		lit_step(CH_TWO, ACT_NONE),
		hex_step(CS_ADDR, 2'd3),
		hex_step(CS_ADDR, 2'd2),
		hex_step(CS_ADDR, 2'd1),
		hex_step(CS_ADDR, 2'd0),
		hex_step(CS_ACS, 2'd1),
		hex_step(CS_ACS, 2'd0),
		lit_step(CH_NL, ACT_SET_ADDR),
		// data record header, jumps to the byte
		lit_step(CH_COLON, ACT_NONE),
		hex_step(CS_RLEN, 2'd1),
		hex_step(CS_RLEN, 2'd0),
		hex_step(CS_OFF, 2'd3),
		hex_step(CS_OFF, 2'd2),
		hex_step(CS_OFF, 2'd1),
		hex_step(CS_OFF, 2'd0),
		lit_step(CH_ZERO, ACT_NONE),
		cw(1'b1, CS_LIT, 2'd0, CH_ZERO, C_ALWAYS, PC_BYT, 1'b0, ACT_OPEN_REC),
		// record checksum and newline
		hex_step(CS_RSUM, 2'd1),
		hex_step(CS_RSUM, 2'd0),
		cw(1'b1, CS_LIT, 2'd0, CH_NL, C_NEVER, PC_SEG, 1'b1, ACT_NONE),
		// data byte; closes the record when it is the last one
		hex_step(CS_DATA, 2'd1),
		cw(1'b1, CS_DATA, 2'd0, CH_NUL, C_TERM, PC_TRM, 1'b1, ACT_TAKE_BYTE)
	};

	function automatic ctl_t ucode(input pc_t pc);
		return (int'(pc) < NSTEPS) ? UCODE[pc] : CW_HALT;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

endpackage
`default_nettype wire

/* hdl/ihex_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module ihex_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ihex_pkg::pc_t start_pc,
	input  wire logic          fire,
	input  wire logic          term,
	output ihex_pkg::ctl_t     ctl,
	output logic               busy,
	output logic               last
);
	import ihex_pkg::*;

	pc_t  pc_q;
	logic busy_q;
	logic taken;

	assign ctl  = ucode(pc_q);
	assign busy = busy_q;

	always_comb begin
		unique case (ctl.cond)
			C_ALWAYS: taken = 1'b1;
			C_TERM:   taken = term;
			default:  taken = 1'b0;
		endcase
	end

	// final step of the item: finishing and not jumping
	assign last = ctl.fin && !taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_SEG;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= start_pc;
			busy_q <= 1'b1;
		end else if (fire) begin
			if (taken) begin
				pc_q <= ctl.target;
			end else if (ctl.fin) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 6'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ihex_dp.sv */
// Datapath: segment counters, record checksum, dispatch and character selection.
`default_nettype none
module ihex_dp #(
	parameter int RECORD_BYTES = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     command,
	input  wire logic [7:0]     data_byte,
	input  wire logic           fire,
	input  wire ihex_pkg::ctl_t ctl,
	input  wire logic [19:0]    segment_base,
	input  wire logic [15:0]    segment_length,
	output ihex_pkg::pc_t       start_pc,
	output logic                term,
	output logic [7:0]          character,
	output logic                excess
);
	import ihex_pkg::*;

	localparam int PW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(RECORD_BYTES - 1);

	logic [15:0]   off_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    sum_q;
	logic          addr_sent_q;
	logic [7:0]    data_q;

	logic          in_range;
	logic [15:0]   left;
	logic [7:0]    reclen;
	logic [15:0]   addr;
	logic [7:0]    acs;
	logic [7:0]    rsum_neg;
	logic [15:0]   val;
	logic [3:0]    nibble;

	assign in_range = off_q < segment_length;
	assign left     = segment_length - off_q;
	assign reclen   = (left >= 16'(RECORD_BYTES)) ? 8'(RECORD_BYTES) : left[7:0];
	assign term     = (pos_q == POS_LAST) || ((off_q + 16'd1) == segment_length);
	assign addr     = segment_base[19:4];
	assign acs      = 8'h00 - (8'h04 + addr[7:0] + addr[15:8]);
	assign rsum_neg = 8'h00 - sum_q;

	always_comb begin
		unique case (command)
			CMD_DATA: begin
				if (!in_range) begin
					start_pc = PC_EXC;
				end else if (!addr_sent_q) begin
					start_pc = PC_ADR;
				end else if (pos_q != '0) begin
					start_pc = PC_BYT;
				end else begin
					start_pc = PC_HDR;
				end
			end
			CMD_END_SEG:  start_pc = PC_SEG;
			CMD_END_FILE: start_pc = PC_EOF;
			default:      start_pc = PC_IGN;
		endcase
	end

	always_comb begin
		unique case (ctl.csel)
			CS_ADDR: val = addr;
			CS_ACS:  val = {8'h00, acs};
			CS_RLEN: val = {8'h00, reclen};
			CS_OFF:  val = off_q;
			CS_DATA: val = {8'h00, data_q};
			CS_RSUM: val = {8'h00, rsum_neg};
			default: val = 16'h0000;
		endcase
	end

	assign nibble = 4'(val >> {ctl.nib, 2'b00});

	always_comb begin
		unique case (ctl.csel)
			CS_LIT:    character = ctl.lit;
			CS_EXCESS: character = CH_NUL;
			default:   character = hex_char(nibble);
		endcase
	end

	assign excess = (ctl.csel == CS_EXCESS);

	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			addr_sent_q <= 1'b0;
		end else if (fire) begin
			case (ctl.act)
				ACT_CLEAR: begin
					off_q       <= '0;
					pos_q       <= '0;
					sum_q       <= '0;
					addr_sent_q <= 1'b0;
				end
				ACT_SET_ADDR: addr_sent_q <= 1'b1;
				ACT_OPEN_REC: sum_q <= reclen + off_q[7:0] + off_q[15:8];
				ACT_TAKE_BYTE: begin
					sum_q <= sum_q + data_q;
					off_q <= off_q + 16'd1;
					pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/intel_hex_record_encoder_unit.sv */
// Top level of the Intel HEX record encoder: configuration, handshakes and output register.
//
//  channel   direction  handshake            payload
//  item      in         item_valid/stall     command[1:0], data_byte[7:0]
//  char      out        char_valid/stall     character[7:0], last_of_run, excess
//  cfg       in         cfg_valid/ready      cfg_index[0:0], cfg_data[19:0]
//
// An item is accepted, then runs its microcode steps: the data byte steps for a byte inside
// a record, 3 more steps when it closes the record, 9 more when it opens one, 16 more for the
// address record on a segment's first byte; end of file and end of segment run their own steps.
// The sequencer emits at most one character a cycle; it works on one item at a time.
// Reset clears the counters, the configuration and all valid state.
// A char stall with a character held freezes the sequencer on its current emitting step.
`default_nettype none
module intel_hex_record_encoder_unit #(
	parameter int RECORD_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  data_byte,
	// character channel
	output logic             char_valid,
	input  wire logic        char_stall,
	output logic [7:0]       character,
	output logic             last_of_run,
	output logic             excess,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);
	import ihex_pkg::*;

	logic [19:0] segment_base_q;
	logic [15:0] segment_length_q;

	ctl_t        ctl;
	pc_t         start_pc;
	logic        busy;
	logic        seq_last;
	logic        term;
	logic        accept;
	logic        out_free;
	logic        fire;
	logic [7:0]  dp_char;
	logic        dp_excess;

	logic        char_valid_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        excess_q;

	// registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_base_q   <= '0;
			segment_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEGMENT_BASE:   segment_base_q   <= cfg_data;
				REG_SEGMENT_LENGTH: segment_length_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// hold off new items while the sequencer runs
	assign item_stall = busy;
	assign accept     = item_valid && !busy;

	// the output register frees when empty or when its transfer completes this cycle
	assign out_free = !char_valid_q || !char_stall;
	// a silent step always advances; an emitting step waits for room
	assign fire     = busy && (!ctl.emit || out_free);

	ihex_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.start_pc (start_pc),
		.fire     (fire),
		.term     (term),
		.ctl      (ctl),
		.busy     (busy),
		.last     (seq_last)
	);

	ihex_dp #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (accept),
		.command        (command),
		.data_byte      (data_byte),
		.fire           (fire),
		.ctl            (ctl),
		.segment_base   (segment_base_q),
		.segment_length (segment_length_q),
		.start_pc       (start_pc),
		.term           (term),
		.character      (dp_char),
		.excess         (dp_excess)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (fire && ctl.emit) begin
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	// load the payload only when the register is free, so a stalled character holds
	always_ff @(posedge clk) begin
		if (fire && ctl.emit) begin
			char_q   <= dp_char;
			last_q   <= seq_last;
			excess_q <= dp_excess;
		end
	end

	assign char_valid  = char_valid_q;
	assign character   = char_q;
	assign last_of_run = last_q;
	assign excess      = excess_q;

`ifndef SYNTHESIS
	a_excess_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid_q && excess_q |-> last_q)
		else $error("excess result not marked last");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid_q && !last_q |-> busy)
		else $error("non-final character with idle sequencer");

	a_busy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(fire) && $past(seq_last))
		else $error("sequencer stopped without a final step");

	a_last_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ctl.emit && seq_last |=> char_valid_q && last_q)
		else $error("final character not presented");
`endif

endmodule
`default_nettype wire
